@@ rtl/crse_pkg.sv @@
// Shared types and constants of the Catmull-Rom spline evaluator.
// No dependencies; the front end, queue, back end and top level import this package.
`timescale 1ns / 1ps
package crse_pkg;

  localparam int IDX_W  = 7;           // table index, wide enough for any point count
  localparam int COUNT_W = 7;
  localparam int ACC_W  = 40;          // Horner accumulator
  localparam int U_W    = 17;          // local fraction, Q0.16 with 1.0 included
  localparam int PROD_W = ACC_W + U_W + 1;
  localparam int FRAC_ONE = 65536;

  localparam logic signed [ACC_W-1:0] POS_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] POS_MIN = -ACC_W'(64'sd2147483648);

  typedef enum logic [1:0] {
    MODE_EMPTY,
    MODE_SINGLE,
    MODE_CURVE
  } mode_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_COEF,
    B_MUL,
    B_ADD,
    B_DONE
  } back_state_t;

  // Channel numbers used by the back end while it walks the result fields.
  localparam logic [2:0] CH_X     = 3'd0;
  localparam logic [2:0] CH_Y     = 3'd1;
  localparam logic [2:0] CH_Z     = 3'd2;
  localparam logic [2:0] CH_WIDTH = 3'd3;
  localparam logic [2:0] CH_BANK  = 3'd4;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [31:0] width;
    logic signed [16:0] bank;
  } point_t;

  typedef struct packed {
    logic                       is_eval;
    logic                       wr_en;
    mode_t                      mode;
    logic [3:0][IDX_W-1:0]      idx;
    logic [U_W-1:0]             u;
    logic [5:0]                 wr_index;
    point_t                     pt;
  } entry_t;

endpackage

@@ rtl/crse_front.sv @@
// Front end: holds the point count register, accepts items and classifies them.
// Depends on crse_pkg.
`timescale 1ns / 1ps
module crse_front import crse_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [5:0]         point_index,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [31:0]        point_width,
  input  logic signed [16:0] point_bank,
  input  logic [16:0]        param_t,
  input  logic               full,
  output logic               push,
  output entry_t             entry
);

  logic [COUNT_W-1:0] point_count;
  logic [COUNT_W-1:0] n;
  logic [COUNT_W-1:0] n_m1;
  logic [COUNT_W-1:0] n_m2;
  logic [16:0]        t_c;
  logic [23:0]        scaled;
  logic [7:0]         seg_raw;
  logic [IDX_W-1:0]   seg;
  logic [7:0]         seg_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_write) begin
      point_count <= cfg_data;
    end
  end

  assign in_stall = full;
  assign push     = in_valid & ~full;

  always_comb begin
    n       = (32'(point_count) > MAX_POINTS) ? COUNT_W'(MAX_POINTS) : point_count;
    n_m1    = n - 7'd1;
    n_m2    = n - 7'd2;
    t_c     = (param_t > 17'(FRAC_ONE)) ? 17'(FRAC_ONE) : param_t;
    scaled  = 24'(t_c) * 24'(n_m1);
    seg_raw = scaled[23:16];
    seg     = (seg_raw > {1'b0, n_m2}) ? n_m2 : seg_raw[6:0];
    seg_p2  = {1'b0, seg} + 8'd2;

    entry.is_eval  = operation;
    entry.wr_en    = ({1'b0, point_index} < n);
    entry.wr_index = point_index;
    entry.pt.x     = coord_x;
    entry.pt.y     = coord_y;
    entry.pt.z     = coord_z;
    entry.pt.width = point_width;
    entry.pt.bank  = point_bank;
    entry.u        = 17'(scaled - {1'b0, seg, 16'b0});
    entry.idx      = '0;
    if (n == 7'd0) begin
      entry.mode = MODE_EMPTY;
    end else if (n == 7'd1) begin
      entry.mode = MODE_SINGLE;
    end else begin
      entry.mode   = MODE_CURVE;
      entry.idx[0] = (seg == '0) ? '0 : seg - 7'd1;
      entry.idx[1] = seg;
      entry.idx[2] = seg + 7'd1;
      entry.idx[3] = (seg_p2 < {1'b0, n}) ? seg_p2[6:0] : n_m1;
    end
  end

endmodule

@@ rtl/crse_queue.sv @@
// Two-entry queue of classified items between the front and back ends.
// Depends on crse_pkg.
`timescale 1ns / 1ps
module crse_queue import crse_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/crse_back.sv @@
// Back end: control point memory, read sequencer, shared Horner multiplier and
// output register. Depends on crse_pkg.
`timescale 1ns / 1ps
module crse_back import crse_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  entry_t             head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [31:0]        lane_width,
  output logic signed [16:0] bank_angle,
  output logic               saturated
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  point_t mem [MAX_POINTS];
  point_t rdata;
  point_t pts [4];

  back_state_t state, state_next;
  entry_t      cur;
  logic [2:0]  rd_cnt;
  logic [2:0]  rd_prev;
  logic [2:0]  ch;
  logic [1:0]  pc;
  logic [1:0]  last_pass;
  logic        sat;
  logic        mem_we;
  logic        load_out;
  logic        out_free;
  logic [AW-1:0] raddr;

  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  addend [3];
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [ACC_W-1:0]  acc_new;
  logic signed [ACC_W-1:0]  half;
  logic signed [ACC_W-1:0]  q [4];
  logic signed [31:0]       pos_val;
  logic                     pos_sat;
  logic signed [31:0]       res_x, res_y, res_z;
  logic [31:0]              res_w;
  logic signed [16:0]       res_b;

  assign out_free  = ~out_valid | ~out_stall;
  assign raddr     = AW'(cur.idx[rd_cnt[1:0]]);
  assign rd_prev   = rd_cnt - 3'd1;
  assign last_pass = (ch < CH_WIDTH) ? 2'd2 : 2'd0;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty && head.is_eval) begin
          state_next = B_READ;
        end
      end
      B_READ: begin
        if (rd_cnt == 3'd4) begin
          state_next = (cur.mode == MODE_CURVE) ? B_COEF : B_DONE;
        end
      end
      B_COEF: state_next = B_MUL;
      B_MUL:  state_next = B_ADD;
      B_ADD: begin
        if (pc == last_pass) begin
          state_next = (ch == CH_BANK) ? B_DONE : B_COEF;
        end else begin
          state_next = B_MUL;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop      = (state == B_IDLE) && !empty;
    mem_we   = pop && !head.is_eval && head.wr_en;
    load_out = (state == B_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(head.wr_index)] <= head.pt;
    end
    rdata <= mem[raddr];
  end

  // Operands of the current channel, widened to the accumulator.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (ch)
        CH_X:     q[k] = ACC_W'(pts[k].x);
        CH_Y:     q[k] = ACC_W'(pts[k].y);
        CH_Z:     q[k] = ACC_W'(pts[k].z);
        CH_WIDTH: q[k] = ACC_W'({1'b0, pts[k].width});
        CH_BANK:  q[k] = ACC_W'(pts[k].bank);
        default:  q[k] = '0;
      endcase
    end
  end

  // Round half up back to Q16, add the next Horner term and saturate.
  always_comb begin
    prod_rnd = (prod + PROD_W'(32768)) >>> 16;
    acc_new  = ACC_W'(prod_rnd) + addend[pc];
    half     = (acc_new + ACC_W'(1)) >>> 1;
    pos_sat  = 1'b1;
    if (half > POS_MAX) begin
      pos_val = 32'sh7fffffff;
    end else if (half < POS_MIN) begin
      pos_val = 32'sh80000000;
    end else begin
      pos_val = half[31:0];
      pos_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop) begin
          cur    <= head;
          rd_cnt <= 3'd0;
          ch     <= CH_X;
          pc     <= 2'd0;
          sat    <= 1'b0;
        end
      end
      B_READ: begin
        rd_cnt <= rd_cnt + 3'd1;
        if (rd_cnt != 3'd0) begin
          pts[rd_prev[1:0]] <= rdata;
        end
      end
      B_COEF: begin
        pc <= 2'd0;
        if (ch < CH_WIDTH) begin
          acc       <= -q[0] + (q[1] <<< 1) + q[1] - (q[2] <<< 1) - q[2] + q[3];
          addend[0] <= (q[0] <<< 1) - (q[1] <<< 2) - q[1] + (q[2] <<< 2) - q[3];
          addend[1] <= q[2] - q[0];
          addend[2] <= q[1] <<< 1;
        end else begin
          acc       <= q[2] - q[1];
          addend[0] <= q[1];
          addend[1] <= '0;
          addend[2] <= '0;
        end
      end
      B_MUL: begin
        prod <= acc * $signed({1'b0, cur.u});
      end
      B_ADD: begin
        acc <= acc_new;
        if (pc == last_pass) begin
          ch <= ch + 3'd1;
          case (ch)
            CH_X:     res_x <= pos_val;
            CH_Y:     res_y <= pos_val;
            CH_Z:     res_z <= pos_val;
            CH_WIDTH: res_w <= acc_new[31:0];
            CH_BANK:  res_b <= acc_new[16:0];
            default:  res_b <= res_b;
          endcase
          if (ch < CH_WIDTH && pos_sat) begin
            sat <= 1'b1;
          end
        end else begin
          pc <= pc + 2'd1;
        end
      end
      default: begin
        rd_cnt <= rd_cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      case (cur.mode)
        MODE_CURVE: begin
          pos_x      <= res_x;
          pos_y      <= res_y;
          pos_z      <= res_z;
          lane_width <= res_w;
          bank_angle <= res_b;
          saturated  <= sat;
        end
        MODE_SINGLE: begin
          pos_x      <= pts[0].x;
          pos_y      <= pts[0].y;
          pos_z      <= pts[0].z;
          lane_width <= pts[0].width;
          bank_angle <= '0;
          saturated  <= 1'b0;
        end
        default: begin
          pos_x      <= '0;
          pos_y      <= '0;
          pos_z      <= '0;
          lane_width <= '0;
          bank_angle <= '0;
          saturated  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ rtl/catmull_rom_spline_evaluator_top.sv @@
// Top level of the uniform Catmull-Rom spline evaluator.
// Depends on crse_pkg, crse_front, crse_queue and crse_back.
//
//   Channel   Handshake                 Payload
//   cfg       cfg_write                 cfg_data (point_count)
//   input     in_valid / in_stall       operation, point_index, coord_x/y/z,
//                                       point_width, point_bank, param_t
//   output    out_valid / out_stall     pos_x/y/z, lane_width, bank_angle, saturated
//
// A write item is stored as the back end takes it from the queue. An evaluate item
// runs five reads on the single memory read port, three cubic passes (coefficients,
// then three multiply-adds) and two linear passes (coefficients, one multiply-add)
// on the one shared multiplier, then the output load, before the next item is taken.
// Reset is synchronous and active high; it empties the queue, drops out_valid and
// clears the point count. The table contents are not cleared.
// The two-entry queue lets the input side keep accepting items while the back end
// works or the output is stalled; in_stall rises only when the queue is full.
`timescale 1ns / 1ps
module catmull_rom_spline_evaluator_top import crse_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [5:0]         point_index,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [31:0]        point_width,
  input  logic signed [16:0] point_bank,
  input  logic [16:0]        param_t,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [31:0]        lane_width,
  output logic signed [16:0] bank_angle,
  output logic               saturated
);

  // Classified item on its way from the front end into the queue.
  entry_t push_data;
  entry_t head;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  // The front end resolves the point count, clamps t, picks the segment and the
  // four neighbour indices, so the back end only reads and computes.
  crse_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .point_index (point_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .point_width (point_width),
    .point_bank  (point_bank),
    .param_t     (param_t),
    .full        (full),
    .push        (push),
    .entry       (push_data)
  );

  crse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  // Writes and evaluations leave the queue in order, so a table write always
  // lands before any later evaluation reads it.
  crse_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .lane_width (lane_width),
    .bank_angle (bank_angle),
    .saturated  (saturated)
  );

endmodule

@@ rtl/crse_checker.sv @@
// Port-level checks for the spline evaluator, bound to the top level.
// Depends on catmull_rom_spline_evaluator_top.
`timescale 1ns / 1ps
module crse_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] pos_y,
  input logic signed [31:0] pos_z,
  input logic               saturated
);

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(pos_y) && $stable(pos_z))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Reset empties the queue, so items are taken right away.
  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  // A raised flag means some coordinate sits at a range limit.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (pos_x == 32'sh7fffffff) || (pos_x == 32'sh80000000) ||
      (pos_y == 32'sh7fffffff) || (pos_y == 32'sh80000000) ||
      (pos_z == 32'sh7fffffff) || (pos_z == 32'sh80000000))
    else $error("saturated without a clamped coordinate");

endmodule

bind catmull_rom_spline_evaluator_top crse_checker u_crse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pos_x     (pos_x),
  .pos_y     (pos_y),
  .pos_z     (pos_z),
  .saturated (saturated)
);

@@ bench/tb_top.sv @@
// Self-checking bench for the Catmull-Rom spline evaluator top level.
// Holds a scoreboard class with its own fixed-point curve predictor; needs only the RTL.
`timescale 1ns / 1ps

localparam logic OP_WRITE = 1'b0;
localparam logic OP_EVAL  = 1'b1;
localparam int   TABLE_DEPTH = 64;

typedef struct {
  logic               op;
  logic [5:0]         idx;
  logic signed [31:0] x, y, z;
  logic [31:0]        w;
  logic signed [16:0] bank;
  logic [16:0]        t;
} spline_item_t;

typedef struct {
  logic signed [31:0] x, y, z;
  logic [31:0]        w;
  logic signed [16:0] bank;
  logic               sat;
} spline_sample_t;

class spline_scoreboard;
  logic signed [31:0] px[TABLE_DEPTH], py[TABLE_DEPTH], pz[TABLE_DEPTH];
  logic [31:0]        pw[TABLE_DEPTH];
  logic signed [16:0] pb[TABLE_DEPTH];
  bit                 written[TABLE_DEPTH];
  int unsigned        point_count;
  spline_sample_t     curve_q[$];
  int                 errors, evals, stores, clamps;

  function new();
    point_count = 0;
    foreach (written[i]) written[i] = 0;
  endfunction

  function int active_points();
    return (point_count > TABLE_DEPTH) ? TABLE_DEPTH : point_count;
  endfunction

  function bit table_ready();
    for (int i = 0; i < active_points(); i++)
      if (!written[i]) return 0;
    return 1;
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 20) $display("MISMATCH: %s", msg);
  endfunction

  function longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function longint cubic(longint p0, longint p1, longint p2, longint p3, longint u);
    longint c3, c2, c1, a;
    c3 = -p0 + 3 * p1 - 3 * p2 + p3;
    c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c1 = p2 - p0;
    a = round_q16(c3 * u) + c2;
    a = round_q16(a * u) + c1;
    a = round_q16(a * u) + 2 * p1;
    return (a + 1) >>> 1;
  endfunction

  function logic signed [31:0] clamp32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      flag = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function void note_item(spline_item_t it);
    int n, seg, i0, i1, i2, i3;
    longint t, scaled, u, lw, lb;
    bit flag;
    spline_sample_t r;
    n = active_points();
    if (it.op == OP_WRITE) begin
      if (it.idx < n) begin
        px[it.idx] = it.x; py[it.idx] = it.y; pz[it.idx] = it.z;
        pw[it.idx] = it.w; pb[it.idx] = it.bank;
        written[it.idx] = 1;
        stores++;
      end
      return;
    end
    evals++;
    r = '{default: 0};
    if (n == 1) begin
      r.x = px[0]; r.y = py[0]; r.z = pz[0]; r.w = pw[0];
    end else if (n > 1) begin
      t = (it.t > 17'd65536) ? 65536 : longint'(it.t);
      scaled = t * (n - 1);
      seg = scaled >>> 16;
      if (seg > n - 2) seg = n - 2;
      u = scaled - longint'(seg) * 65536;
      i0 = (seg > 0) ? seg - 1 : 0;
      i1 = seg;
      i2 = seg + 1;
      i3 = (seg + 2 < n) ? seg + 2 : n - 1;
      flag = 0;
      r.x = clamp32(cubic(px[i0], px[i1], px[i2], px[i3], u), flag);
      r.y = clamp32(cubic(py[i0], py[i1], py[i2], py[i3], u), flag);
      r.z = clamp32(cubic(pz[i0], pz[i1], pz[i2], pz[i3], u), flag);
      lw = longint'(pw[i1]) + round_q16((longint'(pw[i2]) - longint'(pw[i1])) * u);
      lb = longint'(pb[i1]) + round_q16((longint'(pb[i2]) - longint'(pb[i1])) * u);
      r.w = lw[31:0];
      r.bank = lb[16:0];
      r.sat = flag;
      if (flag) clamps++;
    end
    curve_q.insert(curve_q.size(), r);
  endfunction

  function void check_result(spline_sample_t got);
    spline_sample_t e;
    if (curve_q.size() == 0) begin
      report("result arrived with nothing expected");
      return;
    end
    e = curve_q.pop_front();
    if (got.x !== e.x) report($sformatf("pos_x %h, expected %h", got.x, e.x));
    if (got.y !== e.y) report($sformatf("pos_y %h, expected %h", got.y, e.y));
    if (got.z !== e.z) report($sformatf("pos_z %h, expected %h", got.z, e.z));
    if (got.w !== e.w) report($sformatf("lane_width %h, expected %h", got.w, e.w));
    if (got.bank !== e.bank)
      report($sformatf("bank_angle %h, expected %h", got.bank, e.bank));
    if (got.sat !== e.sat) report($sformatf("saturated %b, expected %b", got.sat, e.sat));
  endfunction
endclass

module tb_top;
  // Generous cycle budget: it covers the back-end work of each evaluate item plus the
  // random output stalls and input gaps, for about a thousand items and the idle
  // pauses between phases.
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 50;
  localparam int ITEM_TARGET = 950;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_write = 0;
  logic [6:0]         cfg_data = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               operation = 0;
  logic [5:0]         point_index = '0;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [31:0]        point_width = '0;
  logic signed [16:0] point_bank = '0;
  logic [16:0]        param_t = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [31:0]        lane_width;
  logic signed [16:0] bank_angle;
  logic               saturated;

  spline_scoreboard sb;
  bit  quiet = 0;           // set for the final stretch: no gaps and no stalls
  int  sent = 0;
  int  cycles = 0;
  int  stall_left = 0;

  catmull_rom_spline_evaluator_top dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .point_index(point_index),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .point_width(point_width), .point_bank(point_bank), .param_t(param_t),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .lane_width(lane_width), .bank_angle(bank_angle), .saturated(saturated)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side. Results are sampled at the edge where they are taken, and the stall
  // is driven in random bursts so that it lands on every phase of the back end.
  always @(posedge clk) begin
    if (sb != null && !rst && out_valid && !out_stall)
      sb.check_result('{pos_x, pos_y, pos_z, lane_width, bank_angle, saturated});
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 12);
    end
    out_stall <= (stall_left > 0);
  end

  // Coordinates lean towards the extremes now and then so that the cubic overshoots
  // and the saturation path gets exercised.
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom();
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic logic [16:0] pick_param();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic spline_item_t point_item(int idx);
    spline_item_t it;
    it.op = OP_WRITE;
    it.idx = 6'(idx);
    it.x = pick_coord(); it.y = pick_coord(); it.z = pick_coord();
    it.w = $urandom();
    it.bank = 17'(int'($urandom_range(0, 92160)) - 46080);
    it.t = 17'($urandom_range(0, 131071));
    return it;
  endfunction

  function automatic spline_item_t eval_item(logic [16:0] t);
    spline_item_t it;
    it = point_item($urandom_range(0, 63));
    it.op = OP_EVAL;
    it.t = t;
    return it;
  endfunction

  // Presents one item, holding it until the block takes it, with an optional gap first.
  task automatic send_item(spline_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1;
    operation <= it.op;
    point_index <= it.idx;
    coord_x <= it.x; coord_y <= it.y; coord_z <= it.z;
    point_width <= it.w;
    point_bank <= it.bank;
    param_t <= it.t;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    sent++;
    if (sent > ITEM_TARGET - 120) quiet = 1;
  endtask

  // Drains the block and lets any trailing write items retire before the point
  // count is changed.
  task automatic settle();
    in_valid <= 0;
    while (sb.curve_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_point_count(int unsigned n);
    settle();
    cfg_write <= 1;
    cfg_data <= 7'(n);
    @(posedge clk);
    cfg_write <= 0;
    sb.point_count = n;
  endtask

  task automatic directed_items();
    spline_item_t it;
    // Empty curve: every field comes back zero.
    set_point_count(0);
    send_item(eval_item(17'd40000));
    // Single point with extreme fields: that point comes back with zero banking.
    set_point_count(1);
    it = point_item(0);
    it.x = 32'sh7fffffff; it.y = 32'sh80000000; it.z = 0;
    it.w = 32'hffffffff; it.bank = 17'sd46080;
    send_item(it);
    send_item(eval_item(17'd32768));
    // Four points alternating between the coordinate extremes overshoot the range.
    set_point_count(4);
    for (int i = 0; i < 4; i++) begin
      it = point_item(i);
      it.x = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
      it.y = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
      it.z = i * 65536;
      it.w = (i % 2) ? 32'hffffffff : 32'h0;
      it.bank = (i % 2) ? -17'sd46080 : 17'sd46080;
      send_item(it);
    end
    // A write past the point count is dropped by the block.
    it = point_item(5);
    send_item(it);
    send_item(eval_item(17'd0));
    send_item(eval_item(17'd21845));
    send_item(eval_item(17'd32768));
    send_item(eval_item(17'd65535));
    send_item(eval_item(17'd65536));
    send_item(eval_item(17'd131071));
    // Two points: both ends are clamped at once.
    set_point_count(2);
    send_item(eval_item(17'd16384));
    send_item(eval_item(17'd65536));
  endtask

  // One random phase: fill every active entry, then mostly evaluate, with rewrites
  // and writes past the count mixed in as noise.
  task automatic random_phase(int unsigned count);
    int n;
    int r;
    set_point_count(count);
    n = sb.active_points();
    for (int i = 0; i < n; i++) send_item(point_item(i));
    for (int k = 0; k < 40; k++) begin
      r = $urandom_range(0, 19);
      if (r < 13 && sb.table_ready()) send_item(eval_item(pick_param()));
      else if (r < 18 && n > 0) send_item(point_item($urandom_range(0, n - 1)));
      else if (n < TABLE_DEPTH) send_item(point_item($urandom_range(n, 63)));
      else send_item(eval_item(pick_param()));
    end
  endtask

  initial begin
    int unsigned counts[8] = '{0, 1, 2, 3, 64, 127, 65, 5};
    int phases;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed_items();
    phases = 0;
    while (sent < ITEM_TARGET) begin
      if (phases < 8) random_phase(counts[phases]);
      else if ($urandom_range(0, 3) == 0) random_phase($urandom_range(0, 127));
      else random_phase($urandom_range(2, 12));
      phases++;
    end
    settle();
    $display("Covered %0d items over %0d phases: %0d curve evaluations, %0d stored points,",
             sent, phases + 4, sb.evals, sb.stores);
    $display("%0d evaluations saturated; %0d mismatches.", sb.clamps, sb.errors);
    if (sb.errors == 0 && sb.curve_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/crse_pkg.sv
rtl/crse_front.sv
rtl/crse_queue.sv
rtl/crse_back.sv
rtl/catmull_rom_spline_evaluator_top.sv
rtl/crse_checker.sv
bench/tb_top.sv
